// ===== sv/tdpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpc_pkg: shared types and constants for the trial division prime counter
// Field widths, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int COUNT_WIDTH = 16;
  localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   first;
  } in_item_t;

  typedef struct packed {
    logic                   prime_flag;
    logic [COUNT_WIDTH-1:0] primes_seen;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } tdpc_state_t;

endpackage

// ===== sv/trial_division_prime_counter_top.sv =====
`timescale 1ns / 1ps
// Sequence: 0 and 1 go from IDLE straight to DONE; 2 and 3 pass a CHECK, where
//   the bound already holds; otherwise each trial divisor takes a CHECK and a
//   bit-serial DIV pass over all bits of the value; DONE waits for out_free.
// Throughput: one item at a time; the next transfer follows its result's load.
// Reset: synchronous active-low rst_n clears the sequencer, output valid and
//   the prime tally.
// ----------------------------------------------------------------------------
// trial_division_prime_counter_top
// Primality by trial division with a bit-serial remainder unit and a
// saturating count of primes.
// ----------------------------------------------------------------------------
module trial_division_prime_counter_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tdpc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tdpc_pkg::out_item_t  out_data
);

  localparam int W  = tdpc_pkg::VALUE_WIDTH;
  localparam int CW = tdpc_pkg::COUNT_WIDTH;
  localparam int BW = tdpc_pkg::BIT_CNT_WIDTH;

  tdpc_pkg::tdpc_state_t state_r, state_nxt;

  logic [W-1:0]  val_r,   val_nxt;     // value under test
  logic [W-1:0]  sh_r,    sh_nxt;      // rotating copy, MSB feeds the divider
  logic [W-1:0]  div_r,   div_nxt;     // trial divisor
  logic [W:0]    sq_r,    sq_nxt;      // div_r squared
  logic [W-1:0]  rem_r,   rem_nxt;     // partial remainder
  logic [BW-1:0] cnt_r,   cnt_nxt;     // bits left in this division
  logic          first_r, first_nxt;
  logic          prime_r, prime_nxt;
  logic [CW-1:0] tally_r, tally_nxt;
  logic          out_valid_r, out_valid_nxt;
  tdpc_pkg::out_item_t out_data_r, out_data_nxt;

  logic          in_xfer;
  logic          out_free;
  logic          bound_hit;
  logic [W:0]    rem_sh;
  logic          rem_ge;
  logic [W:0]    rem_sub;
  logic          last_bit;
  logic [CW-1:0] tally_base;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign bound_hit = sq_r > {1'b0, val_r};
  assign rem_sh    = {rem_r, sh_r[W-1]};
  assign rem_ge    = rem_sh >= {1'b0, div_r};
  assign rem_sub   = rem_sh - {1'b0, div_r};
  assign last_bit  = cnt_r == BW'(1);
  assign tally_base = first_r ? '0 : tally_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdpc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_data.value < W'(2)) ? tdpc_pkg::ST_DONE : tdpc_pkg::ST_CHECK;
        end
      end
      tdpc_pkg::ST_CHECK: begin
        state_nxt = bound_hit ? tdpc_pkg::ST_DONE : tdpc_pkg::ST_DIV;
      end
      tdpc_pkg::ST_DIV: begin
        if (last_bit) begin
          state_nxt = (rem_nxt == '0) ? tdpc_pkg::ST_DONE : tdpc_pkg::ST_CHECK;
        end
      end
      tdpc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = tdpc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tdpc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall      = state_r != tdpc_pkg::ST_IDLE;
    val_nxt       = val_r;
    sh_nxt        = sh_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    prime_nxt     = prime_r;
    tally_nxt     = tally_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      tdpc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          val_nxt   = in_data.value;
          first_nxt = in_data.first;
          prime_nxt = 1'b0;
          div_nxt   = W'(2);
          sq_nxt    = (W + 1)'(4);
        end
      end
      tdpc_pkg::ST_CHECK: begin
        if (bound_hit) begin
          prime_nxt = 1'b1;
        end else begin
          sh_nxt  = val_r;
          rem_nxt = '0;
          cnt_nxt = BW'(W);
        end
      end
      tdpc_pkg::ST_DIV: begin
        // one restoring step per cycle, rotate the value back into place
        rem_nxt = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        sh_nxt  = {sh_r[W-2:0], sh_r[W-1]};
        cnt_nxt = cnt_r - BW'(1);
        if (last_bit) begin
          // (d+1)^2 = d^2 + 2d + 1
          sq_nxt  = sq_r + {div_r, 1'b1};
          div_nxt = div_r + W'(1);
        end
      end
      tdpc_pkg::ST_DONE: begin
        if (out_free) begin
          tally_nxt = tally_base;
          if (prime_r && (tally_base != {CW{1'b1}})) begin
            tally_nxt = tally_base + CW'(1);
          end
          out_valid_nxt            = 1'b1;
          out_data_nxt.prime_flag  = prime_r;
          out_data_nxt.primes_seen = tally_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdpc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      tally_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tally_r     <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    sh_r       <= sh_nxt;
    div_r      <= div_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    first_r    <= first_nxt;
    prime_r    <= prime_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tdpc_pkg::ST_DIV |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

  a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdpc_pkg::ST_CHECK || state_r == tdpc_pkg::ST_DIV) |-> div_r >= W'(2))
    else $error("trial divisor below two");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tdpc_pkg::ST_DONE))
    else $error("result raised outside completion");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped while stalled");

  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tally_r != $past(tally_r)) && $past(rst_n) |-> $past(state_r == tdpc_pkg::ST_DONE))
    else $error("tally changed outside completion");

endmodule
